### hdl/ipbt_pkg.sv
// ipbt_pkg: shared types and constants for the IP address text formatter.
// Used by the front classifier, the descriptor queue and the back character sequencer.
`default_nettype none
package ipbt_pkg;

  localparam int GROUPS = 8;

  // separator that closes a group
  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_DOT   = 2'd2;

  localparam logic [6:0] CH_NUL       = 7'h00;
  localparam logic [6:0] CH_COLON     = 7'h3A;
  localparam logic [6:0] CH_DOT       = 7'h2E;
  localparam logic [6:0] CH_ZERO      = 7'h30;
  localparam logic [6:0] CH_HEX_ALPHA = 7'h37;  // 'A' - 10

  // One printed group: leading colons, digits (most significant first), separator.
  typedef struct packed {
    logic [1:0]  lead;
    logic [2:0]  ndig;
    logic [15:0] digits;   // hex nibbles or BCD digits
    logic [1:0]  sep;
  } grp_t;

  // Everything the back end needs to print one address.
  typedef struct packed {
    logic                failed;
    logic [GROUPS-1:0]   live;    // groups that print at least one character
    grp_t [GROUPS-1:0]   grp;
  } desc_t;

  function automatic logic [2:0] grp_len(input grp_t g);
    logic [2:0] sep_cnt;
    sep_cnt = (g.sep != SEP_NONE) ? 3'd1 : 3'd0;
    return {1'b0, g.lead} + g.ndig + sep_cnt;
  endfunction

endpackage
`default_nettype wire

### hdl/ipbt_front.sv
// ipbt_front: registers an incoming address, classifies it (IPv4, compatible,
// mapped, plain IPv6) and builds the print descriptor. Depends on ipbt_pkg.
`default_nettype none
module ipbt_front
  import ipbt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        kind,
  input  wire logic [63:0] addr_high,
  input  wire logic [63:0] addr_low,
  input  wire logic [6:0]  buffer_room,
  output      logic        push_valid,
  input  wire logic        push_ready,
  output      desc_t       push_desc
);

  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [63:0] s1_hi_r;
  logic [63:0] s1_lo_r;
  logic [6:0]  s1_room_r;

  function automatic grp_t octet_grp(input logic [7:0] v, input logic last);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    grp_t        g;
    hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = (hund == 2'd2) ? 7'(v - 8'd200) : ((hund == 2'd1) ? 7'(v - 8'd100) : v[6:0]);
    // rem / 10 by reciprocal, exact for rem below 100
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - ({3'b000, tens} * 7'd10));
    g.lead   = 2'd0;
    g.digits = {4'h0, 2'b00, hund, tens, ones};
    g.ndig   = (v >= 8'd100) ? 3'd3 : ((v >= 8'd10) ? 3'd2 : 3'd1);
    g.sep    = last ? SEP_NONE : SEP_DOT;
    return g;
  endfunction

  function automatic grp_t hex_grp(input logic [15:0] w, input logic last, input logic lead1);
    grp_t g;
    g.lead   = {1'b0, lead1};
    g.digits = w;
    g.ndig   = (w >= 16'h1000) ? 3'd4 : (w >= 16'h0100) ? 3'd3 :
               (w >= 16'h0010) ? 3'd2 : 3'd1;
    g.sep    = last ? SEP_NONE : SEP_COLON;
    return g;
  endfunction

  assign push_valid = s1_valid_r;
  assign in_ready   = !s1_valid_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= kind;
      s1_hi_r   <= addr_high;
      s1_lo_r   <= addr_low;
      s1_room_r <= buffer_room;
    end
  end

  logic [127:0] addr;
  logic [15:0]  word [GROUPS];
  logic [GROUPS-1:0] run;
  logic [GROUPS-1:0] after_run;
  logic [31:0]  lo32;
  logic [31:0]  mid;
  logic         compat;
  logic         mapped;
  grp_t [GROUPS-1:0] grp;
  logic [5:0]   total;
  logic [GROUPS-1:0] live;

  always_comb begin
    logic seen;
    logic prev_run;
    logic [2:0] glen;
    addr   = {s1_hi_r, s1_lo_r};
    lo32   = s1_lo_r[31:0];
    mid    = s1_lo_r[63:32];
    compat = (s1_hi_r == 64'd0) && (mid == 32'd0) && (lo32 != 32'd0) && (lo32 != 32'd1);
    mapped = (s1_hi_r == 64'd0) && (mid == 32'h0000FFFF);

    // first run of zero words
    seen     = 1'b0;
    prev_run = 1'b0;
    for (int k = 0; k < GROUPS; k++) begin
      word[k]  = addr[127-16*k -: 16];
      run[k]   = (word[k] == 16'd0) && (prev_run || !seen);
      seen     = seen || (word[k] == 16'd0);
      prev_run = run[k];
    end
    // group k directly follows a collapsed word
    after_run = {run[GROUPS-2:0], 1'b0};

    grp = '0;
    if (!s1_kind_r) begin
      for (int o = 0; o < 4; o++) begin
        grp[o] = octet_grp(lo32[31-8*o -: 8], o == 3);
      end
    end else if (compat || mapped) begin
      grp[0].lead = 2'd2;
      if (mapped) begin
        grp[0].digits = 16'hFFFF;
        grp[0].ndig   = 3'd4;
        grp[0].sep    = SEP_COLON;
      end
      for (int o = 0; o < 4; o++) begin
        grp[o+1] = octet_grp(lo32[31-8*o -: 8], o == 3);
      end
    end else begin
      for (int k = 0; k < GROUPS; k++) begin
        if (run[k]) begin
          // the collapsed run prints one colon at the very start and one at the very end
          grp[k].lead = ((k == 0) || (k == GROUPS-1)) ? 2'd1 : 2'd0;
        end else begin
          grp[k] = hex_grp(word[k], k == GROUPS-1, after_run[k]);
        end
      end
    end

    total = 6'd0;
    for (int k = 0; k < GROUPS; k++) begin
      glen    = grp_len(grp[k]);
      live[k] = (glen != 3'd0);
      total   = total + {3'b000, glen};
    end

    push_desc.grp    = grp;
    push_desc.live   = live;
    push_desc.failed = (s1_room_r <= {1'b0, total});
  end

endmodule
`default_nettype wire

### hdl/ipbt_queue.sv
// ipbt_queue: small first-word-fall-through queue of print descriptors
// between the front classifier and the back sequencer. Depends on ipbt_pkg.
`default_nettype none
module ipbt_queue
  import ipbt_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output      logic  wr_ready,
  input  wire desc_t wr_data,
  output      logic  rd_valid,
  input  wire logic  rd_ready,
  output      desc_t rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [AW-1:0]  wptr_r;
  logic [AW-1:0]  rptr_r;
  logic [CW-1:0]  count_r;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### hdl/ipbt_back.sv
// ipbt_back: walks the groups of the head descriptor and emits one character
// per cycle while out_ready allows, through an output register. Depends on ipbt_pkg.
`default_nettype none
module ipbt_back
  import ipbt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_valid,
  output      logic       rd_ready,
  input  wire desc_t      head,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [6:0] out_char,
  output      logic       out_last,
  output      logic       out_failed
);

  logic              started_r;
  logic [GROUPS-1:0] pend_r;
  logic [2:0]        pos_r;
  logic              out_valid_r;
  logic [6:0]        out_char_r;
  logic              out_last_r;
  logic              out_failed_r;

  logic [GROUPS-1:0] pend_eff;
  logic [2:0]        cur;
  logic [GROUPS-1:0] cur_mask;
  grp_t              g;
  logic [2:0]        glen;
  logic [2:0]        lead3;
  logic [2:0]        didx;
  logic [3:0]        nib;
  logic [6:0]        ch;
  logic              grp_end;
  logic              is_last;
  logic              fire;

  always_comb begin
    logic [15:0] shifted;
    pend_eff = started_r ? pend_r : head.live;
    cur = 3'd0;
    for (int k = GROUPS-1; k >= 0; k--) begin
      if (pend_eff[k]) begin
        cur = 3'(k);
      end
    end
    cur_mask = GROUPS'(1) << cur;
    g        = head.grp[cur];
    glen     = grp_len(g);
    lead3    = {1'b0, g.lead};
    // digit position counted from the least significant digit
    didx     = 3'(g.ndig - 3'd1 - (pos_r - lead3));
    shifted  = g.digits >> {didx[1:0], 2'b00};
    nib      = shifted[3:0];

    if (head.failed) begin
      ch = CH_NUL;
    end else if (pos_r < lead3) begin
      ch = CH_COLON;
    end else if (pos_r < lead3 + g.ndig) begin
      ch = (nib < 4'd10) ? CH_ZERO + {3'b000, nib} : CH_HEX_ALPHA + {3'b000, nib};
    end else begin
      ch = (g.sep == SEP_DOT) ? CH_DOT : CH_COLON;
    end

    grp_end = (pos_r == glen - 3'd1);
    is_last = head.failed || (grp_end && ((pend_eff & ~cur_mask) == '0));
  end

  assign fire     = rd_valid && (!out_valid_r || out_ready);
  assign rd_ready = fire && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      pend_r      <= '0;
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        if (is_last) begin
          started_r <= 1'b0;
          pos_r     <= 3'd0;
        end else if (grp_end) begin
          started_r <= 1'b1;
          pend_r    <= pend_eff & ~cur_mask;
          pos_r     <= 3'd0;
        end else begin
          started_r <= 1'b1;
          pend_r    <= pend_eff;
          pos_r     <= pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r   <= ch;
      out_last_r   <= is_last;
      out_failed_r <= head.failed;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_failed = out_failed_r;

endmodule
`default_nettype wire

### hdl/ip_address_binary_to_text.sv
// Flow: an accepted address is registered in the front stage, written into the descriptor
// queue and then emitted through the back sequencer's output register.
// Throughput: one character per cycle while out_tready allows; a text has 2 to 39
// characters, a failed address one null character. The back sequencer sets this.
// Reset: synchronous active-low rst_n clears all handshake and sequencing state.
`default_nettype none
module ip_address_binary_to_text
  import ipbt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [135:0] in_tdata,   // addr_high[63:0], addr_low[127:64], buffer_room[134:128]
  input  wire logic         in_tuser,   // kind
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [7:0]   out_tdata,  // text_char[6:0]
  output      logic         out_tlast,
  output      logic         out_tuser   // failed
);

  logic       push_valid;
  logic       push_ready;
  desc_t      push_desc;
  logic       head_valid;
  logic       head_ready;
  desc_t      head_desc;
  logic [6:0] out_char;

  ipbt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .kind        (in_tuser),
    .addr_high   (in_tdata[63:0]),
    .addr_low    (in_tdata[127:64]),
    .buffer_room (in_tdata[134:128]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_desc   (push_desc)
  );

  ipbt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_desc),
    .rd_valid (head_valid),
    .rd_ready (head_ready),
    .rd_data  (head_desc)
  );

  ipbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (head_valid),
    .rd_ready   (head_ready),
    .head       (head_desc),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast),
    .out_failed (out_tuser)
  );

  assign out_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

### hdl/ipbt_checker.sv
// ipbt_checker: port-level checks on the address formatter's result stream,
// bound to ip_address_binary_to_text. No package dependency.
`default_nettype none
module ipbt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [7:0]   out_tdata,
  input wire logic         out_tlast,
  input wire logic         out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a failure is a lone null result that closes the address
  a_fail_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("malformed failure result");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata == 8'h3A) || (out_tdata == 8'h2E) ||
      ((out_tdata >= 8'h30) && (out_tdata <= 8'h39)) ||
      ((out_tdata >= 8'h41) && (out_tdata <= 8'h46)))
    else $error("character outside the address alphabet");

endmodule

bind ip_address_binary_to_text ipbt_checker u_ipbt_checker (.*);
`default_nettype wire

### verif/tb_ip_address_binary_to_text.sv
// Testbench for ip_address_binary_to_text: drives IPv4/IPv6 address requests and checks
// every text character against an in-bench formatter held by a small scoreboard class.
// Depends on hdl/ipbt_pkg.sv and hdl/ip_address_binary_to_text.sv.
`timescale 1ns / 100ps
`default_nettype none
module tb_ip_address_binary_to_text;
  import ipbt_pkg::*;

  localparam bit          FAM_V4       = 1'b0;
  localparam bit          FAM_V6       = 1'b1;
  localparam logic [31:0] MAPPED_TAG   = 32'h0000FFFF;
  localparam int          REPORT_MAX   = 10;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          RANDOM_ITEMS = 287;
  localparam longint      CYCLE_LIMIT  = 4000000;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       failed;
  } char_rec_t;

  class addr_text_board;
    char_rec_t  expected_chars[$];
    logic [6:0] text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Builds the printed form of an address into text.
    function void render(bit kind, logic [63:0] hi, logic [63:0] lo);
      logic [127:0] a;
      logic [15:0]  w16;
      logic [3:0]   nib;
      bit           dotted;
      bit           inserted;
      bit           running;
      int           v;
      a = {hi, lo};
      text.delete();
      dotted   = 1'b1;
      inserted = 1'b0;
      running  = 1'b0;
      if (kind == FAM_V6) begin
        if (hi == 64'd0 && lo[63:32] == 32'd0 && lo[31:0] > 32'd1) begin
          text.push_back(CH_COLON);
          text.push_back(CH_COLON);
        end else if (hi == 64'd0 && lo[63:32] == MAPPED_TAG) begin
          text.push_back(CH_COLON);
          text.push_back(CH_COLON);
          repeat (4) text.push_back(CH_HEX_ALPHA + 7'd15);
          text.push_back(CH_COLON);
        end else begin
          dotted = 1'b0;
          for (int w = 0; w < 8; w++) begin
            w16 = a[127 - 16 * w -: 16];
            if (w16 == 16'd0 && !inserted) begin
              // only the first zero run collapses
              running = 1'b1;
              if (w == 0) text.push_back(CH_COLON);
            end else begin
              if (running && !inserted) begin
                text.push_back(CH_COLON);
                inserted = 1'b1;
              end
              for (int s = 12; s >= 0; s -= 4) begin
                if (s == 0 || {1'b0, w16} >= (17'd1 << s)) begin
                  nib = w16[s +: 4];
                  text.push_back(nib > 4'd9 ? CH_HEX_ALPHA + nib : CH_ZERO + nib);
                end
              end
              if (w != 7) text.push_back(CH_COLON);
            end
          end
          if (running && !inserted) text.push_back(CH_COLON);
        end
      end
      if (dotted) begin
        for (int b = 3; b >= 0; b--) begin
          v = lo[8 * b +: 8];
          if (v >= 100) text.push_back(CH_ZERO + 7'(v / 100));
          if (v >= 10) text.push_back(CH_ZERO + 7'((v / 10) % 10));
          text.push_back(CH_ZERO + 7'(v % 10));
          if (b != 0) text.push_back(CH_DOT);
        end
      end
    endfunction

    function void note_address(bit kind, logic [63:0] hi, logic [63:0] lo, logic [6:0] room);
      char_rec_t rec;
      render(kind, hi, lo);
      if (int'(room) < text.size() + 1) begin
        rec = '{ch: CH_NUL, last: 1'b1, failed: 1'b1};
        expected_chars.push_back(rec);
      end else begin
        foreach (text[i]) begin
          rec = '{ch: text[i], last: (i == text.size() - 1), failed: 1'b0};
          expected_chars.push_back(rec);
        end
      end
    endfunction

    function void check_char(logic [7:0] data, logic last, logic failed);
      char_rec_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected char data=%h last=%b failed=%b", data, last, failed);
        return;
      end
      want = expected_chars.pop_front();
      if (data !== {1'b0, want.ch} || last !== want.last || failed !== want.failed) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: char exp data=%h last=%b failed=%b got data=%h last=%b failed=%b",
                   {1'b0, want.ch}, want.last, want.failed, data, last, failed);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function bit clean();
      return errors == 0 && expected_chars.size() == 0;
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // addr_high[63:0], addr_low[127:64], buffer_room[134:128]
  logic         in_tuser;   // kind
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;  // text_char[6:0]
  logic         out_tlast;
  logic         out_tuser;  // failed

  addr_text_board board;
  int             tx_idle_pct;
  int             rx_idle_pct;
  bit             hold_req;
  longint         cycles;

  ip_address_binary_to_text uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_address(bit kind, logic [63:0] hi, logic [63:0] lo, logic [6:0] room);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, room, lo, hi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_address(kind, hi, lo, room);
  endtask

  task automatic wait_all_chars();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < rx_idle_pct) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_char(out_tdata, out_tlast, out_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [127:0] a;
    logic [15:0]  w16;
    logic [6:0]   room;
    bit           kind;
    int           r;
    int           len;
    board       = new();
    cycles      = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // IPv4 extremes, exact fit and one short, upper bits ignored
    send_address(FAM_V4, 64'd0, 64'd0, 7'd8);
    send_address(FAM_V4, 64'd0, 64'd0, 7'd7);
    send_address(FAM_V4, '1, '1, 7'd16);
    send_address(FAM_V4, '1, '1, 7'd15);
    send_address(FAM_V4, 64'h0123_4567_89AB_CDEF, 64'hDEAD_BEEF_0A64_09C7, 7'd64);
    send_address(FAM_V4, 64'd0, 64'h0000_0000_C0A8_0101, 7'd0);
    send_address(FAM_V4, 64'd0, 64'h0000_0000_7F00_0001, 7'd127);
    // all zero, loopback (not compatible), compatible, mapped
    send_address(FAM_V6, 64'd0, 64'd0, 7'd3);
    send_address(FAM_V6, 64'd0, 64'd0, 7'd2);
    send_address(FAM_V6, 64'd0, 64'd1, 7'd127);
    send_address(FAM_V6, 64'd0, 64'h0000_0000_0102_0304, 7'd64);
    send_address(FAM_V6, 64'd0, 64'h0000_0000_0000_0002, 7'd12);
    send_address(FAM_V6, 64'd0, 64'h0000_FFFF_C0A8_0101, 7'd64);
    send_address(FAM_V6, 64'd0, 64'h0000_FFFF_0000_0000, 7'd15);
    send_address(FAM_V6, 64'h0000_0000_0000_0001, 64'h0000_FFFF_0102_0304, 7'd64);
    // zero run at the end, in the middle with a later zero word, at the start
    send_address(FAM_V6, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000, 7'd16);
    send_address(FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0003_0004_0005, 7'd64);
    send_address(FAM_V6, 64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000, 7'd64);
    send_address(FAM_V6, 64'h0001_0000_0000_0000, 64'h0000_0000_0102_0304, 7'd64);
    // longest text, exact fit and one short; digit widths one to four
    send_address(FAM_V6, '1, '1, 7'd40);
    send_address(FAM_V6, '1, '1, 7'd39);
    send_address(FAM_V6, 64'h000A_00BC_0DEF_1234, 64'h5678_9ABC_DEF0_0F00, 7'd64);
    send_address(FAM_V6, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 7'd100);
    in_tvalid <= 1'b0;
    wait_all_chars();

    // back-to-back requests against a long output hold-off
    tx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (10)
      send_address(FAM_V6, '1, {32'h1234_5678, $urandom}, 7'd64);
    in_tvalid <= 1'b0;
    wait_all_chars();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // first stretch runs with no idling on either side
      tx_idle_pct = (n < 100) ? 0 : 30;
      rx_idle_pct = (n < 100) ? 0 : 30;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        kind = FAM_V4;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
      end else begin
        kind = FAM_V6;
        for (int w = 0; w < 8; w++) begin
          r = $urandom_range(0, 99);
          if (r < 40) w16 = 16'd0;
          else if (r < 60) w16 = 16'($urandom_range(1, 15));
          else if (r < 70) w16 = 16'hFFFF;
          else w16 = 16'($urandom);
          a[127 - 16 * w -: 16] = w16;
        end
        r = $urandom_range(0, 99);
        if (r < 10) a[127:32] = '0;
        else if (r < 20) a[127:32] = {80'd0, 16'hFFFF};
        else if (r < 25) a = {$urandom, $urandom, $urandom, $urandom};
        hi = a[127:64];
        lo = a[63:0];
      end
      board.render(kind, hi, lo);
      len = board.text.size();
      r = $urandom_range(0, 99);
      if (r < 45) room = 7'($urandom_range(40, 64));
      else if (r < 70) room = 7'(len + $urandom_range(0, 1));
      else if (r < 85) room = 7'($urandom_range(0, 39));
      else room = 7'($urandom_range(65, 127));
      send_address(kind, hi, lo, room);
    end
    in_tvalid <= 1'b0;
    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.clean())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
